// File: rtl/core/hsv_to_rgb888_macros.svh
// Assertion macros for the HSV to RGB888 converter.
`ifndef HSV_TO_RGB888_MACROS_SVH
`define HSV_TO_RGB888_MACROS_SVH
`ifndef SYNTHESIS
`define H2RGB_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");
`define H2RGB_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");
`else
`define H2RGB_ASSERT_IMPL(lbl, ant, con)
`define H2RGB_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

// File: rtl/core/h2rgb_pkg.sv
// Types and constants for the HSV to RGB888 converter.
`timescale 1ns / 1ps
`default_nettype none
package h2rgb_pkg;

  localparam int unsigned HUE_W  = 15;
  localparam int unsigned UNIT_W = 13;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned COMP_W = 25;   // Q24, up to 1.0 inclusive
  localparam int unsigned T_W    = 12;
  localparam int unsigned SECT_W = 3;
  localparam int unsigned CT_W   = COMP_W + T_W;
  localparam int unsigned QIN_W  = CT_W - 8;
  localparam int unsigned RECIP_W = 30;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned Q_W    = QIN_W + RECIP_W;

  localparam logic [HUE_W-1:0]  HUE_FULL    = 15'd23040;
  localparam logic [UNIT_W-1:0] UNIT_ONE    = 13'd4096;
  localparam logic [T_W-1:0]    SECTOR_SPAN = 12'd3840;
  // ceil(2^33 / 15): exact floor division by 15 for inputs below 2^29
  localparam logic [RECIP_W-1:0] RECIP_15   = 30'd572662307;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [UNIT_W-1:0] saturation;
    logic [UNIT_W-1:0] value_level;
  } hsv_pkt_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              out_of_range;
  } rgb_pkt_t;

  function automatic logic [HUE_W-1:0] sector_base(input logic [SECT_W-1:0] sec);
    logic [HUE_W-1:0] b;
    case (sec)
      3'd0:    b = 15'd0;
      3'd1:    b = 15'd3840;
      3'd2:    b = 15'd7680;
      3'd3:    b = 15'd11520;
      3'd4:    b = 15'd15360;
      default: b = 15'd19200;
    endcase
    return b;
  endfunction

  function automatic logic [CHAN_W-1:0] to_channel(input logic [COMP_W-1:0] comp);
    logic [COMP_W+7:0] p;
    p = {comp, 8'd0} - {8'd0, comp};
    return p[COMP_W+6:COMP_W-1];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/hsv_to_rgb888.sv
// HSV to RGB888 converter, five register stages.
// Path: a beat accepted into stage 1 moves through stages 2, 3 and 4 and the
// output register to out_pixel, shown for one cycle; out_valid marks it.
// Throughput: one pixel per clock; busy is held low, the receiver cannot stall.
// Stage depth is set by the 25x12 chroma-by-t multiply and the 29x30
// reciprocal multiply for the divide by 3840.
// Reset: synchronous, rst_n low clears the valid bits of every stage.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb888_macros.svh"
module hsv_to_rgb888 (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire h2rgb_pkg::hsv_pkt_t in_pixel,
  output logic                     out_valid,
  output h2rgb_pkg::rgb_pkt_t      out_pixel
);

  localparam logic [h2rgb_pkg::COMP_W-1:0] COMP_MAX = 25'h1000000;

  // stage 1: range check, sector, t, chroma
  logic                               s1_valid_r, s1_valid_nxt;
  logic                               s1_oor_r, s1_oor_nxt;
  logic [h2rgb_pkg::SECT_W-1:0]       s1_sect_r, s1_sect_nxt;
  logic [h2rgb_pkg::T_W-1:0]          s1_t_r, s1_t_nxt;
  logic [h2rgb_pkg::COMP_W-1:0]       s1_chroma_r, s1_chroma_nxt;
  logic [h2rgb_pkg::UNIT_W-1:0]       s1_val_r;
  // stage 2: chroma*t, m, v
  logic                               s2_valid_r;
  logic                               s2_oor_r;
  logic [h2rgb_pkg::SECT_W-1:0]       s2_sect_r;
  logic [h2rgb_pkg::CT_W-1:0]         s2_ct_r, s2_ct_nxt;
  logic [h2rgb_pkg::COMP_W-1:0]       s2_m_r, s2_m_nxt;
  logic [h2rgb_pkg::COMP_W-1:0]       s2_vfull_r, s2_vfull_nxt;
  // stage 3: reciprocal product
  logic                               s3_valid_r;
  logic                               s3_oor_r;
  logic [h2rgb_pkg::SECT_W-1:0]       s3_sect_r;
  logic [h2rgb_pkg::Q_W-1:0]          s3_q_r, s3_q_nxt;
  logic [h2rgb_pkg::COMP_W-1:0]       s3_m_r;
  logic [h2rgb_pkg::COMP_W-1:0]       s3_vfull_r;
  // stage 4: channel components
  logic                               s4_valid_r;
  logic                               s4_oor_r;
  logic [h2rgb_pkg::COMP_W-1:0]       s4_r_r, s4_r_nxt;
  logic [h2rgb_pkg::COMP_W-1:0]       s4_g_r, s4_g_nxt;
  logic [h2rgb_pkg::COMP_W-1:0]       s4_b_r, s4_b_nxt;
  // stage 5: output
  logic                               out_valid_r;
  h2rgb_pkg::rgb_pkt_t                out_pixel_r, out_pixel_nxt;

  logic [h2rgb_pkg::HUE_W-1:0]        hue_w;
  logic [h2rgb_pkg::HUE_W-1:0]        frac_w;
  logic [2*h2rgb_pkg::UNIT_W-1:0]     vs_w;
  logic [h2rgb_pkg::COMP_W-1:0]       offset_w;
  logic [h2rgb_pkg::COMP_W-1:0]       xm_w;

  assign busy = 1'b0;
  assign s1_valid_nxt = start && !busy;

  always_comb begin
    s1_oor_nxt = (in_pixel.hue > h2rgb_pkg::HUE_FULL) ||
                 (in_pixel.saturation > h2rgb_pkg::UNIT_ONE) ||
                 (in_pixel.value_level > h2rgb_pkg::UNIT_ONE);
    hue_w = (in_pixel.hue == h2rgb_pkg::HUE_FULL) ? '0 : in_pixel.hue;
    if (hue_w < 15'd3840) begin
      s1_sect_nxt = 3'd0;
    end else if (hue_w < 15'd7680) begin
      s1_sect_nxt = 3'd1;
    end else if (hue_w < 15'd11520) begin
      s1_sect_nxt = 3'd2;
    end else if (hue_w < 15'd15360) begin
      s1_sect_nxt = 3'd3;
    end else if (hue_w < 15'd19200) begin
      s1_sect_nxt = 3'd4;
    end else begin
      s1_sect_nxt = 3'd5;
    end
    frac_w = hue_w - h2rgb_pkg::sector_base(s1_sect_nxt);
    if (s1_sect_nxt[0]) begin
      s1_t_nxt = h2rgb_pkg::SECTOR_SPAN - frac_w[h2rgb_pkg::T_W-1:0];
    end else begin
      s1_t_nxt = frac_w[h2rgb_pkg::T_W-1:0];
    end
    vs_w = in_pixel.value_level * in_pixel.saturation;
    s1_chroma_nxt = vs_w[h2rgb_pkg::COMP_W-1:0];
  end

  always_comb begin
    s2_ct_nxt    = {{h2rgb_pkg::T_W{1'b0}}, s1_chroma_r} *
                   {{h2rgb_pkg::COMP_W{1'b0}}, s1_t_r};
    s2_vfull_nxt = {s1_val_r, 12'd0};
    s2_m_nxt     = s2_vfull_nxt - s1_chroma_r;
  end

  // chroma*t / 3840 = (chroma*t >> 8) / 15
  assign s3_q_nxt = {{h2rgb_pkg::RECIP_W{1'b0}}, s2_ct_r[h2rgb_pkg::CT_W-1:8]} *
                    {{h2rgb_pkg::QIN_W{1'b0}}, h2rgb_pkg::RECIP_15};

  always_comb begin
    offset_w = s3_q_r[h2rgb_pkg::RECIP_SHIFT+h2rgb_pkg::COMP_W-1:h2rgb_pkg::RECIP_SHIFT];
    xm_w = offset_w + s3_m_r;
    case (s3_sect_r)
      3'd0: begin
        s4_r_nxt = s3_vfull_r; s4_g_nxt = xm_w;       s4_b_nxt = s3_m_r;
      end
      3'd1: begin
        s4_r_nxt = xm_w;       s4_g_nxt = s3_vfull_r; s4_b_nxt = s3_m_r;
      end
      3'd2: begin
        s4_r_nxt = s3_m_r;     s4_g_nxt = s3_vfull_r; s4_b_nxt = xm_w;
      end
      3'd3: begin
        s4_r_nxt = s3_m_r;     s4_g_nxt = xm_w;       s4_b_nxt = s3_vfull_r;
      end
      3'd4: begin
        s4_r_nxt = xm_w;       s4_g_nxt = s3_m_r;     s4_b_nxt = s3_vfull_r;
      end
      default: begin
        s4_r_nxt = s3_vfull_r; s4_g_nxt = s3_m_r;     s4_b_nxt = xm_w;
      end
    endcase
  end

  always_comb begin
    out_pixel_nxt.out_of_range = s4_oor_r;
    if (s4_oor_r) begin
      out_pixel_nxt.red   = '0;
      out_pixel_nxt.green = '0;
      out_pixel_nxt.blue  = '0;
    end else begin
      out_pixel_nxt.red   = h2rgb_pkg::to_channel(s4_r_r);
      out_pixel_nxt.green = h2rgb_pkg::to_channel(s4_g_r);
      out_pixel_nxt.blue  = h2rgb_pkg::to_channel(s4_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_oor_r    <= s1_oor_nxt;
    s1_sect_r   <= s1_sect_nxt;
    s1_t_r      <= s1_t_nxt;
    s1_chroma_r <= s1_chroma_nxt;
    s1_val_r    <= in_pixel.value_level;
    s2_oor_r    <= s1_oor_r;
    s2_sect_r   <= s1_sect_r;
    s2_ct_r     <= s2_ct_nxt;
    s2_m_r      <= s2_m_nxt;
    s2_vfull_r  <= s2_vfull_nxt;
    s3_oor_r    <= s2_oor_r;
    s3_sect_r   <= s2_sect_r;
    s3_q_r      <= s3_q_nxt;
    s3_m_r      <= s2_m_r;
    s3_vfull_r  <= s2_vfull_r;
    s4_oor_r    <= s3_oor_r;
    s4_r_r      <= s4_r_nxt;
    s4_g_r      <= s4_g_nxt;
    s4_b_r      <= s4_b_nxt;
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  `H2RGB_ASSERT_NEXT(a_accept_enters, start && !busy, s1_valid_r)
  `H2RGB_ASSERT_IMPL(a_t_bound, s1_valid_r && !s1_oor_r, s1_t_r <= h2rgb_pkg::SECTOR_SPAN)
  `H2RGB_ASSERT_IMPL(a_r_bound, s4_valid_r && !s4_oor_r, s4_r_r <= COMP_MAX)
  `H2RGB_ASSERT_IMPL(a_g_bound, s4_valid_r && !s4_oor_r, s4_g_r <= COMP_MAX)
  `H2RGB_ASSERT_IMPL(a_b_bound, s4_valid_r && !s4_oor_r, s4_b_r <= COMP_MAX)
  // with the flag set, it must be the only bit set
  `H2RGB_ASSERT_IMPL(a_oor_black, out_valid && out_pixel.out_of_range, $countones(out_pixel) == 1)

endmodule
`default_nettype wire
